// ----- hdl/dsc_pkg.sv -----
// ----------------------------------------------------------------------------
// dsc_pkg: shared types and constants of the distinct subsequence counter
// Holds the default sizes, the register map and the structs that pass
// between the register file, the counting cells and the top level.
// ----------------------------------------------------------------------------
package dsc_pkg;

  localparam int PATTERN_MAX_DEF = 16;
  localparam int COUNT_WIDTH_DEF = 32;

  // Pattern bytes the two 64-bit pattern registers can hold.
  localparam int PATTERN_REG_BYTES = 16;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 64;
  localparam int LEN_W      = 5;

  typedef enum logic [1:0] {
    REG_PATTERN_LEN = 2'd0,
    REG_PATTERN_LO  = 2'd1,
    REG_PATTERN_HI  = 2'd2
  } dsc_reg_idx_t;

  typedef struct packed {
    logic [LEN_W-1:0] pattern_len;
    logic [63:0]      pattern_lo;
    logic [63:0]      pattern_hi;
  } dsc_cfg_t;

  // Broadcast to every cell for each accepted input beat.
  typedef struct packed {
    logic       valid;
    logic       clear;
    logic [7:0] text_char;
  } dsc_step_t;

endpackage

// ----- hdl/dsc_regs.sv -----
// ----------------------------------------------------------------------------
// dsc_regs: configuration register file
// APB-style write and read access to the pattern length and pattern bytes.
// ----------------------------------------------------------------------------
module dsc_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [dsc_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [dsc_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [dsc_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready,
  output dsc_pkg::dsc_cfg_t                 cfg_o
);

  dsc_pkg::dsc_cfg_t     cfg_r;
  dsc_pkg::dsc_cfg_t     cfg_nxt;
  dsc_pkg::dsc_reg_idx_t reg_idx;
  logic                  wr_en;

  assign cfg_pready = 1'b1;
  assign reg_idx    = dsc_pkg::dsc_reg_idx_t'(cfg_paddr[4:3]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        dsc_pkg::REG_PATTERN_LEN: cfg_nxt.pattern_len = cfg_pwdata[dsc_pkg::LEN_W-1:0];
        dsc_pkg::REG_PATTERN_LO:  cfg_nxt.pattern_lo  = cfg_pwdata[63:0];
        dsc_pkg::REG_PATTERN_HI:  cfg_nxt.pattern_hi  = cfg_pwdata[63:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dsc_pkg::REG_PATTERN_LEN:
        cfg_prdata = {{(dsc_pkg::CFG_DATA_W-dsc_pkg::LEN_W){1'b0}}, cfg_r.pattern_len};
      dsc_pkg::REG_PATTERN_LO: cfg_prdata = cfg_r.pattern_lo;
      dsc_pkg::REG_PATTERN_HI: cfg_prdata = cfg_r.pattern_hi;
      default: cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

// ----- hdl/dsc_cell.sv -----
// ----------------------------------------------------------------------------
// dsc_cell: one prefix counter of the chain
// Holds the count of one pattern prefix, adds the neighbor's count on a
// matching byte and saturates at the all-ones value.
// ----------------------------------------------------------------------------
module dsc_cell #(
  parameter int COUNT_WIDTH = dsc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dsc_pkg::dsc_step_t     step,
  input  logic                   active,
  input  logic [7:0]             pat_byte,
  input  logic [COUNT_WIDTH-1:0] link_i,
  output logic [COUNT_WIDTH-1:0] link_o,
  output logic [COUNT_WIDTH-1:0] count_nxt_o,
  output logic                   sat_o
);

  logic [COUNT_WIDTH-1:0] count_r;
  logic [COUNT_WIDTH-1:0] count_nxt;
  logic [COUNT_WIDTH-1:0] base;
  logic [COUNT_WIDTH:0]   sum;
  logic                   hit;

  // The start of a text clears the count before the byte is applied, and the
  // neighbor sees that cleared value too.
  assign base = step.clear ? '0 : count_r;
  assign sum  = {1'b0, base} + {1'b0, link_i};
  assign hit  = active && (pat_byte == step.text_char);

  always_comb begin
    count_nxt = base;
    if (hit) begin
      count_nxt = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (step.valid) begin
      count_r <= count_nxt;
    end
  end

  assign link_o      = base;
  assign count_nxt_o = count_nxt;
  assign sat_o       = hit & sum[COUNT_WIDTH];

endmodule

// ----- hdl/distinct_subsequence_counter_core.sv -----
// ----------------------------------------------------------------------------
// distinct_subsequence_counter_core: streaming distinct subsequence counter
// Counts the distinct subsequences of a byte stream that equal the pattern
// held in the configuration registers.
// ----------------------------------------------------------------------------
// The core takes one text byte per clock and returns one result beat per
// byte, in the cycle after the byte is taken; with out_tready held high it
// sustains a byte every cycle. Each prefix of the pattern has its own cell in
// a chain, and all cells add their left neighbor's count in the same cycle,
// so the rate is set by one adder per cell plus the prefix select at the
// output register. A set in_tuser bit starts a new text and clears the counts
// and the saturation flag before that byte is applied. A pattern_len of zero
// yields a count of one; lengths above PATTERN_MAX act as PATTERN_MAX. Write
// the registers only while no beat is in flight.
// ----------------------------------------------------------------------------
module distinct_subsequence_counter_core #(
  parameter int PATTERN_MAX = dsc_pkg::PATTERN_MAX_DEF,
  parameter int COUNT_WIDTH = dsc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input stream.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] text_char
  input  logic [0:0]                     in_tuser,   // [0] first_char
  input  logic                           in_tlast,   // last_char
  // Result stream.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [31:0]                    out_tdata,  // [31:0] match_count
  output logic [0:0]                     out_tuser,  // [0] saturated
  output logic                           out_tlast,  // end_of_text
  // Configuration port.
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [dsc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [dsc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [dsc_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  dsc_pkg::dsc_cfg_t  cfg;
  dsc_pkg::dsc_step_t step;

  logic [COUNT_WIDTH-1:0] link      [PATTERN_MAX+1];
  logic [COUNT_WIDTH-1:0] count_nxt [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] cell_sat;

  logic                   accept;
  logic [COUNT_WIDTH-1:0] result;
  logic [31:0]            result_out;
  logic                   sat_r;
  logic                   sat_nxt;

  logic                   out_valid_r;
  logic [31:0]            out_data_r;
  logic                   out_sat_r;
  logic                   out_last_r;

  dsc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign step.valid     = accept;
  assign step.clear     = in_tuser[0];
  assign step.text_char = in_tdata;

  // The empty prefix always counts one.
  assign link[0] = COUNT_WIDTH'(1);

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic [7:0] pat_byte;
    logic       active;

    if (k < 8) begin : g_lo
      assign pat_byte = cfg.pattern_lo[8*k +: 8];
    end else if (k < dsc_pkg::PATTERN_REG_BYTES) begin : g_hi
      assign pat_byte = cfg.pattern_hi[8*(k-8) +: 8];
    end else begin : g_none
      assign pat_byte = 8'h00;
    end

    assign active = k < int'(cfg.pattern_len);

    dsc_cell #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .step        (step),
      .active      (active),
      .pat_byte    (pat_byte),
      .link_i      (link[k]),
      .link_o      (link[k+1]),
      .count_nxt_o (count_nxt[k]),
      .sat_o       (cell_sat[k])
    );
  end

  // Pick the updated count of the longest active prefix.
  always_comb begin
    result = (cfg.pattern_len == '0) ? COUNT_WIDTH'(1) : '0;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if ((k + 1 == int'(cfg.pattern_len)) ||
          ((k == PATTERN_MAX - 1) && (int'(cfg.pattern_len) > PATTERN_MAX))) begin
        result = count_nxt[k];
      end
    end
  end

  if (COUNT_WIDTH >= 32) begin : g_wide
    assign result_out = result[31:0];
  end else begin : g_narrow
    assign result_out = {{(32-COUNT_WIDTH){1'b0}}, result};
  end

  assign sat_nxt = (step.clear ? 1'b0 : sat_r) | (|cell_sat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        sat_r       <= sat_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result_out;
      out_sat_r  <= sat_nxt;
      out_last_r <= in_tlast;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_sat_r;
  assign out_tlast    = out_last_r;

endmodule

// ----- hdl/dsc_checker.sv -----
// ----------------------------------------------------------------------------
// dsc_checker: port-level checks of the counter core
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module dsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [0:0]  in_tuser,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [0:0]  out_tuser,
  input logic        out_tlast
);

  // A result beat waiting on the sink stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat withdrawn while stalled");

  // Every accepted byte shows up as a result beat in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted byte gave no result beat");

  // The end-of-text mark follows its byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tlast == $past(in_tlast))
    else $error("end-of-text mark lost");

  // A single byte after a cleared start cannot saturate any count.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] |=> !out_tuser[0])
    else $error("saturation flag survived the start of a text");

  // An empty output stage never blocks the input.
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output stage");

endmodule

bind distinct_subsequence_counter_core dsc_checker u_dsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ----- tb/sv/distinct_subsequence_counter_core_tb.sv -----
// ----------------------------------------------------------------------------
// distinct_subsequence_counter_core_tb: self-checking bench for the counter
// Streams text bytes through the core under random bursts and result-side
// stalls, predicts every result beat from a shadow copy of the prefix
// counters and the pattern registers, and compares each beat in order.
// ----------------------------------------------------------------------------
module distinct_subsequence_counter_core_tb;

  localparam int STALL_LIMIT = 2000;
  localparam int BEAT_TARGET = 720;

  typedef struct packed {
    logic [7:0] text_char;
    logic       first_char;
    logic       last_char;
  } text_beat_t;

  typedef struct packed {
    logic [31:0] match_count;
    logic        saturated;
    logic        end_of_text;
  } count_beat_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [7:0]                     in_tdata = '0;  // [7:0] text_char
  logic [0:0]                     in_tuser = '0;  // [0] first_char
  logic                           in_tlast = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [31:0]                    out_tdata;      // [31:0] match_count
  logic [0:0]                     out_tuser;      // [0] saturated
  logic                           out_tlast;
  logic                           cfg_psel = 1'b0;
  logic                           cfg_penable = 1'b0;
  logic                           cfg_pwrite = 1'b0;
  logic [dsc_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [dsc_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [dsc_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                           cfg_pready;

  // Beats waiting to be sent and result beats waiting to arrive.
  text_beat_t  text_q[$];
  count_beat_t count_q[$];

  // Shadow of the registers and of the prefix counters.
  logic [dsc_pkg::LEN_W-1:0] pat_len_sh = '0;
  logic [63:0]               pat_lo_sh = '0;
  logic [63:0]               pat_hi_sh = '0;
  logic [31:0]               prefix_cnt [dsc_pkg::PATTERN_MAX_DEF];
  logic                      sat_sticky = 1'b0;

  int unsigned fail_count = 0;
  int unsigned beats_total = 0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  int unsigned rx_tick = 0;
  int unsigned idle_cycles = 0;

  distinct_subsequence_counter_core dut (.*);

  always #5 clk = ~clk;

  initial begin
    foreach (prefix_cnt[k]) prefix_cnt[k] = '0;
  end

  // Advances the shadow counters by one text byte and returns the result beat.
  function automatic count_beat_t step_counts(input text_beat_t b);
    int          eff_len;
    int          k;
    logic [7:0]  pbyte;
    logic [31:0] add;
    logic [32:0] sum;
    count_beat_t r;
    eff_len = (pat_len_sh > dsc_pkg::PATTERN_MAX_DEF) ? dsc_pkg::PATTERN_MAX_DEF
                                                      : int'(pat_len_sh);
    if (b.first_char) begin
      foreach (prefix_cnt[i]) prefix_cnt[i] = '0;
      sat_sticky = 1'b0;
    end
    // Walk downward so each prefix adds the old count of the one before it.
    for (k = eff_len - 1; k >= 0; k--) begin
      if (k < 8) begin
        pbyte = pat_lo_sh[8*k +: 8];
      end else begin
        pbyte = pat_hi_sh[8*(k-8) +: 8];
      end
      if (pbyte == b.text_char) begin
        if (k == 0) begin
          add = 32'd1;
        end else begin
          add = prefix_cnt[k-1];
        end
        sum = {1'b0, prefix_cnt[k]} + {1'b0, add};
        if (sum[32]) begin
          prefix_cnt[k] = '1;
          sat_sticky = 1'b1;
        end else begin
          prefix_cnt[k] = sum[31:0];
        end
      end
    end
    if (eff_len == 0) begin
      r.match_count = 32'd1;
    end else begin
      r.match_count = prefix_cnt[eff_len-1];
    end
    r.saturated = sat_sticky;
    r.end_of_text = b.last_char;
    return r;
  endfunction

  // Driver: bursts of beats with random gaps between them.
  always @(posedge clk) begin
    text_beat_t nb;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (text_q.size() != 0) begin
        nb = text_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= nb.text_char;
        in_tuser <= nb.first_char;
        in_tlast <= nb.last_char;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: switches between always ready, random stalls and a fixed cadence.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_left <= $urandom_range(20, 120);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 1) == 1);
      default: out_tready <= ((rx_tick % 5) == 0);
    endcase
  end

  // Monitor: predicts on every accepted text beat and checks every result beat.
  always @(posedge clk) begin
    text_beat_t  tb_in;
    count_beat_t got;
    count_beat_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        tb_in = '{text_char: in_tdata, first_char: in_tuser[0], last_char: in_tlast};
        count_q = {count_q, step_counts(tb_in)};
      end
      if (out_tvalid && out_tready) begin
        got = '{match_count: out_tdata, saturated: out_tuser[0], end_of_text: out_tlast};
        if (count_q.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing expected: count %0d sat %0b last %0b",
                   $time, got.match_count, got.saturated, got.end_of_text);
        end else begin
          want = count_q.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t: expected count %0d sat %0b last %0b, got count %0d sat %0b last %0b",
                     $time, want.match_count, want.saturated, want.end_of_text,
                     got.match_count, got.saturated, got.end_of_text);
          end
        end
      end
    end
  end

  // Watchdog on cycles in which no beat and no register write goes through.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("distinct_subsequence_counter_core_tb: FAIL");
        $finish;
      end
    end
  end

  task automatic add_beat(input logic [7:0] ch, input logic is_first, input logic is_last);
    text_beat_t nb;
    nb = '{text_char: ch, first_char: is_first, last_char: is_last};
    text_q = {text_q, nb};
    beats_total++;
  endtask

  // Returns once everything sent has come back, plus an idle margin.
  task automatic wait_idle();
    @(negedge clk);
    while (text_q.size() != 0 || in_tvalid || count_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input dsc_pkg::dsc_reg_idx_t idx, input logic [63:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      dsc_pkg::REG_PATTERN_LEN: pat_len_sh = value[dsc_pkg::LEN_W-1:0];
      dsc_pkg::REG_PATTERN_LO:  pat_lo_sh = value;
      dsc_pkg::REG_PATTERN_HI:  pat_hi_sh = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_pattern(input int unsigned len, input logic [63:0] lo,
                             input logic [63:0] hi);
    wait_idle();
    write_reg(dsc_pkg::REG_PATTERN_LEN, 64'(len));
    write_reg(dsc_pkg::REG_PATTERN_LO, lo);
    write_reg(dsc_pkg::REG_PATTERN_HI, hi);
  endtask

  initial begin
    logic [7:0]  sym [4];
    logic [7:0]  ch;
    logic [63:0] lo;
    logic [63:0] hi;
    logic        is_first;
    logic        is_last;
    int unsigned len;
    int unsigned n_texts;
    int unsigned tlen;
    int unsigned phase;
    int          i;
    int          k;
    int          t;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty pattern straight out of reset, first beat without a start flag.
    add_beat(8'h00, 1'b0, 1'b0);
    add_beat(8'hFF, 1'b1, 1'b1);

    // Two-byte pattern with the extreme byte values.
    set_pattern(2, 64'h0000_0000_0000_00FF, 64'h0);
    add_beat(8'hFF, 1'b1, 1'b0);
    add_beat(8'h00, 1'b0, 1'b0);
    add_beat(8'hFF, 1'b0, 1'b0);
    add_beat(8'h00, 1'b0, 1'b1);

    // Shorten and restore the length in the middle of a text.
    wait_idle();
    write_reg(dsc_pkg::REG_PATTERN_LEN, 64'd1);
    add_beat(8'hFF, 1'b0, 1'b0);
    wait_idle();
    write_reg(dsc_pkg::REG_PATTERN_LEN, 64'd2);
    add_beat(8'h00, 1'b0, 1'b1);

    // Length field at its maximum acts as the full sixteen bytes.
    set_pattern(31, '1, '1);
    add_beat(8'hFF, 1'b1, 1'b0);
    add_beat(8'hFF, 1'b0, 1'b1);

    // Full-length pattern of distinct bytes, text equal to it.
    lo = 64'h8877_6655_4433_2211;
    hi = 64'h00FF_EEDD_CCBB_AA99;
    set_pattern(16, lo, hi);
    for (k = 0; k < 16; k++) begin
      ch = (k < 8) ? lo[8*k +: 8] : hi[8*(k%8) +: 8];
      add_beat(ch, k == 0, k == 15);
    end

    phase = 0;
    while (beats_total < BEAT_TARGET) begin
      if ($urandom_range(0, 5) == 0) begin
        // A run of one repeated byte against a pattern of that byte saturates.
        ch = 8'($urandom_range(0, 255));
        set_pattern($urandom_range(12, 31), {8{ch}}, {8{ch}});
        tlen = $urandom_range(45, 70);
        for (i = 0; i < tlen; i++)
          add_beat(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : ch,
                   i == 0, i == tlen - 1);
        for (i = 0; i < 5; i++)
          add_beat(ch, i == 0, i == 4);
      end else begin
        for (k = 0; k < 4; k++) begin
          case ($urandom_range(0, 5))
            0: sym[k] = 8'h00;
            1: sym[k] = 8'hFF;
            default: sym[k] = 8'($urandom_range(0, 255));
          endcase
        end
        case ($urandom_range(0, 9))
          0: len = 0;
          1: len = $urandom_range(17, 31);
          2: len = 16;
          default: len = $urandom_range(1, 15);
        endcase
        if ($urandom_range(0, 4) == 0) begin
          lo = {$urandom, $urandom};
          hi = {$urandom, $urandom};
        end else begin
          for (k = 0; k < 8; k++) begin
            lo[8*k +: 8] = sym[$urandom_range(0, 3)];
            hi[8*k +: 8] = sym[$urandom_range(0, 3)];
          end
        end
        set_pattern(len, lo, hi);
        n_texts = $urandom_range(2, 5);
        for (t = 0; t < n_texts; t++) begin
          tlen = $urandom_range(1, 30);
          for (i = 0; i < tlen; i++) begin
            ch = ($urandom_range(0, 99) < 85) ? sym[$urandom_range(0, 3)]
                                              : 8'($urandom_range(0, 255));
            is_first = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 39) == 0);
            is_last = (i == tlen - 1) ? ($urandom_range(0, 9) != 0)
                                      : ($urandom_range(0, 39) == 0);
            add_beat(ch, is_first, is_last);
          end
          // Hold the sender back until every result of the first text is in.
          if (t == 0 && (phase == 1 || $urandom_range(0, 7) == 0))
            wait_idle();
        end
      end
      phase++;
    end

    wait_idle();
    if (fail_count == 0)
      $display("distinct_subsequence_counter_core_tb: PASS");
    else
      $display("distinct_subsequence_counter_core_tb: FAIL");
    $finish;
  end

endmodule
